### hdl/edfts_pkg.sv
// Shared types and constants of the earliest-deadline-first task scheduler.
`default_nettype none
package edfts_pkg;
	localparam int MAX_TASKS  = 64;
	localparam int MAX_DAY    = 255;
	localparam int IDX_W      = $clog2(MAX_TASKS);
	localparam int CNT_W      = $clog2(MAX_TASKS + 1);
	localparam int DAY_W      = 8;
	localparam int VAL_W      = 8;
	localparam int ID_W       = 7;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] remaining;
		logic [DAY_W-1:0] deadline;
		logic [DAY_W-1:0] release_day;
	} task_entry_t;

	typedef struct packed {
		logic dl_eq;
		logic better;
		logic nonzero;
	} cmp_flags_t;
endpackage
`default_nettype wire

### hdl/edf_unit_task_scheduler_unit.sv
// Top level of the earliest-deadline-first scheduler for unit-time tasks.
// The slave stream carries commands: tuser holds the command (clear, load, tick)
// and tdata holds release day, deadline day and duration of a load.
// Clear and load beats take effect in the cycle they are accepted and give no result.
// A tick beat starts a scan of the task table, one entry per cycle through a single
// compare unit fed by the table's registered read port. The tick steps through the
// scan, drain and finish states; the drain state judges the last entry read, and the
// finish state registers the result beat and returns to idle. With an empty table
// the tick goes straight from idle to the finish state.
// The tick result is one master beat: day, served task id, deadline flag, done flag.
// The block accepts no beat while a tick is in progress.
// The result sits in an output register; a new command is accepted while it waits,
// and a following tick holds at its last step until the receiver takes the old beat.
// Reset empties the table and sets the day to one; table contents stay undefined
// until loaded and are never read before that.
`default_nettype none
module edf_unit_task_scheduler_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [23:0] s_tdata,  // release_day[7:0], deadline_day[15:8], duration[23:16]
	input  wire [1:0]  s_tuser,  // cmd[1:0]
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [23:0] m_tdata  // day_number[7:0], served_task[14:8], deadline_hit[15],
	                             // all_done[16], zero fill[23:17]
);
	import edfts_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [DAY_W-1:0] day_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;
	logic             hit_q;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	task_entry_t      best_q;
	logic [CNT_W-1:0] nz_q;
	logic             m_tvalid_q;
	logic [23:0]      m_tdata_q;

	logic             accept;
	cmd_t             cmd;
	task_entry_t      in_entry;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	task_entry_t      wr_data;
	task_entry_t      rd_data;
	cmp_flags_t       flags;
	logic             serve;
	logic             last_gone;
	logic [CNT_W-1:0] nz_after;
	logic             done;
	logic             out_free;
	logic [ID_W-1:0]  served_id;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cmd      = cmd_t'(s_tuser);

	always_comb begin
		in_entry.release_day = s_tdata[7:0];
		in_entry.deadline    = s_tdata[15:8];
		in_entry.remaining   = s_tdata[23:16];
	end

	assign serve     = found_q && !hit_q;
	assign last_gone = serve && (best_q.remaining == VAL_W'(1));
	assign nz_after  = nz_q - CNT_W'(last_gone);
	assign done      = (nz_after == '0);
	assign out_free  = !m_tvalid_q || m_tready;
	assign served_id = serve ? (ID_W'(best_idx_q) + ID_W'(1)) : '0;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = best_q;
		if (state_q == ST_IDLE) begin
			wr_en   = accept && (cmd == CMD_LOAD) && (count_q < CNT_W'(MAX_TASKS));
			wr_addr = count_q[IDX_W-1:0];
			wr_data = in_entry;
		end else if (state_q == ST_FINISH) begin
			wr_en             = serve && out_free;
			wr_data.remaining = best_q.remaining - VAL_W'(1);
		end
	end

	edfts_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	edfts_cmp u_cmp (
		.day           (day_q),
		.entry         (rd_data),
		.best_found    (found_q),
		.best_deadline (best_q.deadline),
		.flags         (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			day_q      <= DAY_W'(1);
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			found_q    <= 1'b0;
			nz_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			vld_s1 <= (state_q == ST_SCAN);
			if (vld_s1) begin
				hit_q <= hit_q || flags.dl_eq;
				nz_q  <= nz_q + CNT_W'(flags.nonzero);
				if (flags.better) begin
					found_q    <= 1'b1;
					best_idx_q <= idx_s1;
					best_q     <= rd_data;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								day_q   <= DAY_W'(1);
							end
							CMD_LOAD: begin
								if (count_q < CNT_W'(MAX_TASKS)) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_TICK: begin
								idx_q   <= '0;
								hit_q   <= 1'b0;
								found_q <= 1'b0;
								nz_q    <= '0;
								state_q <= (count_q == '0) ? ST_FINISH : ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					idx_s1 <= idx_q;
					if (idx_q == IDX_W'(count_q - CNT_W'(1))) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tdata_q <= {7'b0, done, hit_q, served_id, day_q};
						if (day_q < DAY_W'(MAX_DAY)) begin
							day_q <= day_q + DAY_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule
`default_nettype wire

### hdl/edfts_table.sv
// Task table memory with one write port and one registered read port.
`default_nettype none
module edfts_table (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire [edfts_pkg::IDX_W-1:0] wr_addr,
	input  wire edfts_pkg::task_entry_t wr_data,
	input  wire [edfts_pkg::IDX_W-1:0] rd_addr,
	output edfts_pkg::task_entry_t     rd_data
);
	import edfts_pkg::*;

	task_entry_t mem_q [MAX_TASKS];
	task_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

### hdl/edfts_cmp.sv
// Shared compare unit that judges one table entry against the day and the best so far.
`default_nettype none
module edfts_cmp (
	input  wire [edfts_pkg::DAY_W-1:0] day,
	input  wire edfts_pkg::task_entry_t entry,
	input  wire                        best_found,
	input  wire [edfts_pkg::DAY_W-1:0] best_deadline,
	output edfts_pkg::cmp_flags_t      flags
);
	import edfts_pkg::*;

	logic open_task;

	always_comb begin
		open_task     = (entry.release_day <= day) && (day < entry.deadline) &&
		                (entry.remaining != '0);
		flags.dl_eq   = (entry.deadline == day);
		flags.better  = open_task && (!best_found || (entry.deadline < best_deadline));
		flags.nonzero = (entry.remaining != '0);
	end
endmodule
`default_nettype wire

### tb/edf_sched_checker.sv
// Checker for the scheduler: it tracks the task table, predicts each tick report and compares.
module edf_sched_checker
	import edfts_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [23:0] s_tdata,
	input  wire [1:0]  s_tuser,
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [23:0] m_tdata,
	output int         failures,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DAY_W-1:0] day;
		logic [ID_W-1:0]  served;
		logic             hit;
		logic             done;
	} day_report_t;

	logic [DAY_W-1:0] rel_days [MAX_TASKS];
	logic [DAY_W-1:0] dl_days [MAX_TASKS];
	logic [VAL_W-1:0] left_days [MAX_TASKS];
	int               loaded;
	logic [DAY_W-1:0] today;
	day_report_t      reports_due [$];
	int               mismatches;

	always @(posedge clk or negedge arst_n) begin : track
		day_report_t want;
		day_report_t got;
		int          best;
		int          i;
		if (!arst_n) begin
			loaded = 0;
			today = DAY_W'(1);
			reports_due.delete();
			mismatches = 0;
			pending <= 0;
			failures <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.day = m_tdata[7:0];
				got.served = m_tdata[14:8];
				got.hit = m_tdata[15];
				got.done = m_tdata[16];
				if (reports_due.size() == 0) begin
					$error("result beat with no tick waiting: day_number %0d", got.day);
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					if (got.day !== want.day) begin
						$error("day_number: expected %0d, actual %0d", want.day, got.day);
						mismatches++;
					end
					if (got.served !== want.served) begin
						$error("served_task: expected %0d, actual %0d", want.served, got.served);
						mismatches++;
					end
					if (got.hit !== want.hit) begin
						$error("deadline_hit: expected %0d, actual %0d", want.hit, got.hit);
						mismatches++;
					end
					if (got.done !== want.done) begin
						$error("all_done: expected %0d, actual %0d", want.done, got.done);
						mismatches++;
					end
					if (m_tdata[23:17] !== 7'd0) begin
						$error("zero fill: expected 0, actual %0h", m_tdata[23:17]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (cmd_t'(s_tuser))
				CMD_CLEAR: begin
					loaded = 0;
					today = DAY_W'(1);
				end
				CMD_LOAD: begin
					if (loaded < MAX_TASKS) begin
						rel_days[loaded] = s_tdata[7:0];
						dl_days[loaded] = s_tdata[15:8];
						left_days[loaded] = s_tdata[23:16];
						loaded++;
					end
				end
				CMD_TICK: begin
					want.day = today;
					want.served = '0;
					want.hit = 1'b0;
					want.done = 1'b1;
					best = -1;
					for (i = 0; i < loaded; i++)
						if (dl_days[i] == today)
							want.hit = 1'b1;
					if (!want.hit) begin
						for (i = 0; i < loaded; i++)
							if (rel_days[i] <= today && today < dl_days[i] &&
									left_days[i] != 0 &&
									(best < 0 || dl_days[i] < dl_days[best]))
								best = i;
						if (best >= 0) begin
							left_days[best] = left_days[best] - VAL_W'(1);
							want.served = ID_W'(best + 1);
						end
					end
					for (i = 0; i < loaded; i++)
						if (left_days[i] != 0)
							want.done = 1'b0;
					reports_due = {reports_due, want};
					if (today < MAX_DAY)
						today = today + DAY_W'(1);
				end
				default: ;
				endcase
			end
			pending <= reports_due.size();
			failures <= mismatches;
		end
	end
endmodule

### tb/tb.sv
// Testbench top for the scheduler: reset, command stimulus under idle and stall phases, and the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import edfts_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [23:0] m_tdata;
	int          failures;
	int          pending;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          beats_sent = 0;

	always #5 clk = ~clk;

	edf_unit_task_scheduler_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	edf_sched_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.failures (failures),
		.pending  (pending)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	task automatic put_beat(input cmd_t cmd, input logic [7:0] rel, input logic [7:0] dl,
			input logic [7:0] dur);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {dur, dl, rel};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int         seq;
		int         kind;
		int         n_tasks;
		int         n_ticks;
		int         horizon;
		logic [7:0] rel;
		logic [7:0] dl;
		logic [7:0] dur;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_beat(CMD_TICK, 8'd0, 8'd0, 8'd0);
		put_beat(CMD_NONE, 8'd255, 8'd255, 8'd255);
		put_beat(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
		put_beat(CMD_LOAD, 8'd1, 8'd255, 8'd0);
		put_beat(CMD_LOAD, 8'd255, 8'd3, 8'd255);
		put_beat(CMD_LOAD, 8'd1, 8'd5, 8'd2);
		put_beat(CMD_LOAD, 8'd1, 8'd5, 8'd1);
		put_beat(CMD_LOAD, 8'd2, 8'd4, 8'd1);
		repeat (7) put_beat(CMD_TICK, 8'd0, 8'd0, 8'd0);
		put_beat(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
		put_beat(CMD_LOAD, 8'd1, 8'd1, 8'd255);
		put_beat(CMD_TICK, 8'd0, 8'd0, 8'd0);
		put_beat(CMD_TICK, 8'd0, 8'd0, 8'd0);

		seq = 0;
		while (beats_sent < 1030) begin
			case (seq % 4)
			0: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			1: begin
				tx_idle_pct = 75;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct = 0;
				rx_stall_pct = 75;
			end
			default: begin
				tx_idle_pct = 7;
				rx_stall_pct = 7;
			end
			endcase
			if (seq == 1)
				kind = 1;
			else if (seq == 2)
				kind = 2;
			else
				kind = $urandom_range(11);
			if (kind == 0) begin
				repeat ($urandom_range(5, 15))
					put_beat(cmd_t'($urandom_range(3)), 8'($urandom_range(1, 255)),
						8'($urandom_range(1, 255)), 8'($urandom_range(255)));
			end else begin
				put_beat(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
				n_tasks = (kind == 1) ? $urandom_range(1, 6) :
					(kind == 2) ? MAX_TASKS + $urandom_range(1, 3) : $urandom_range(1, 10);
				n_ticks = (kind == 1) ? 260 : $urandom_range(5, 40);
				horizon = (kind == 1) ? 255 : n_ticks + 5;
				repeat (n_tasks) begin
					rel = 8'($urandom_range(1, horizon));
					dl = 8'($urandom_range(1, horizon));
					dur = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
						8'($urandom_range(6));
					put_beat(CMD_LOAD, rel, dl, dur);
				end
				repeat (n_ticks) put_beat(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
			end
			if (seq == 3 || $urandom_range(7) == 0)
				wait_results();
			seq++;
		end

		wait_results();
		repeat (80) @(posedge clk);
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
